// ===== sv/sbwr_pkg.sv =====
// ----------------------------------------------------------------------------
// sbwr_pkg
// shared types, command codes, limits and the crc-8 lookup table for the
// smart battery word responder
// ----------------------------------------------------------------------------
package sbwr_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int MV_W   = 14;
    localparam int WORD_W = 16;
    localparam int PCT_W  = 7;
    localparam int PROD_W = 23;

    // item modes
    localparam logic [1:0] MODE_SENSE = 2'd0;
    localparam logic [1:0] MODE_CMD   = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_DESIGN_CAP = 2'd0;
    localparam logic [1:0] REG_FULL_CAP   = 2'd1;
    localparam logic [1:0] REG_CYCLES     = 2'd2;
    localparam logic [1:0] REG_TEMP       = 2'd3;

    // word commands
    localparam logic [7:0] CMD_TEMP       = 8'h08;
    localparam logic [7:0] CMD_VOLTAGE    = 8'h09;
    localparam logic [7:0] CMD_CURRENT    = 8'h0A;
    localparam logic [7:0] CMD_REL_CHARGE = 8'h0D;
    localparam logic [7:0] CMD_REM_CAP    = 8'h0F;
    localparam logic [7:0] CMD_FULL_CAP   = 8'h10;
    localparam logic [7:0] CMD_CYCLES     = 8'h17;
    localparam logic [7:0] CMD_CELL_ONE   = 8'h3F;
    localparam logic [7:0] CMD_CELL_TWO   = 8'h3E;
    localparam logic [7:0] CMD_CELL_THREE = 8'h3D;

    // smbus framing bytes
    localparam logic [7:0] ADDR_WRITE = 8'h16;
    localparam logic [7:0] ADDR_READ  = 8'h17;
    localparam logic [7:0] CRC_POLY   = 8'h07;

    // voltage limits in mV
    localparam logic [MV_W-1:0] CELL_FLOOR = 14'd1000;
    localparam logic [MV_W-1:0] PACK_FLOOR = 14'd3000;
    localparam logic [MV_W-1:0] PACK_EMPTY = 14'd9000;
    localparam logic [MV_W-1:0] PACK_FULL  = 14'd12600;

    // divide by 36 and by 100 through reciprocal multiply
    localparam int              PCT_SHIFT   = 18;
    localparam logic [12:0]     PCT_MUL     = 13'd7282;
    localparam int              CAP_SHIFT   = 30;
    localparam logic [23:0]     CAP_MUL     = 24'd10737419;

    // reset values of the registers
    localparam logic [WORD_W-1:0] DESIGN_CAP_RST = 16'd1480;
    localparam logic [WORD_W-1:0] FULL_CAP_RST   = 16'd1480;
    localparam logic [WORD_W-1:0] CYCLES_RST     = 16'd1;
    localparam logic [WORD_W-1:0] TEMP_RST       = 16'd2982;

    typedef logic [7:0] crc_tab_t [256];

    typedef struct packed {
        logic [WORD_W-1:0] design_capacity;
        logic [WORD_W-1:0] full_capacity;
        logic [WORD_W-1:0] cycle_total;
        logic [WORD_W-1:0] temperature_value;
    } cfg_t;

    function automatic crc_tab_t crc_table_gen();
        crc_tab_t   tab;
        logic [7:0] c;
        for (int i = 0; i < 256; i++)
        begin
            c = 8'(i);
            for (int k = 0; k < 8; k++)
            begin
                c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
            end
            tab[i] = c;
        end
        return tab;
    endfunction

    localparam crc_tab_t CRC_TABLE = crc_table_gen();

    // crc after address byte, command code zero and the read address
    localparam logic [7:0] PREFIX_RST =
        CRC_TABLE[CRC_TABLE[CRC_TABLE[ADDR_WRITE]] ^ ADDR_READ];

    function automatic logic is_word_cmd(input logic [7:0] cmd);
        logic hit;
        hit = (cmd == CMD_TEMP)     || (cmd == CMD_VOLTAGE)    ||
              (cmd == CMD_CURRENT)  || (cmd == CMD_REL_CHARGE) ||
              (cmd == CMD_REM_CAP)  || (cmd == CMD_FULL_CAP)   ||
              (cmd == CMD_CYCLES)   || (cmd == CMD_CELL_ONE)   ||
              (cmd == CMD_CELL_TWO) || (cmd == CMD_CELL_THREE);
        return hit;
    endfunction

endpackage

// ===== sv/smart_battery_word_responder_core.sv =====
// ----------------------------------------------------------------------------
// smart_battery_word_responder_core
// sensor latch, command store and smbus word reply with pec
// path: a read request passes the s1 and s2 registers into the output buffer
// throughput: one item per cycle while in_stall is low; a read reply takes
// three output transfers; the buffer loads the next reply as the last leaves
// reset: all sensor state and the command clear to zero, registers to defaults
// ----------------------------------------------------------------------------
module smart_battery_word_responder_core
    import sbwr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        mode,
    input  logic [7:0]        command_byte,
    input  logic [MV_W-1:0]   tap1_mv,
    input  logic [MV_W-1:0]   tap2_mv,
    input  logic [MV_W-1:0]   pack_mv,
    input  logic [WORD_W-1:0] current_ma,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        reply_byte,
    output logic              last_byte
);

    cfg_t              cfg;

    logic [7:0]        cmd_reg;
    logic [7:0]        prefix_reg;
    logic [MV_W-1:0]   cell1_reg;
    logic [MV_W-1:0]   cell2_reg;
    logic [MV_W-1:0]   cell3_reg;
    logic [MV_W-1:0]   pack_reg;
    logic [WORD_W-1:0] draw_reg;
    logic [PCT_W-1:0]  pct_reg;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_is_cap_reg;
    logic [PROD_W-1:0] s1_value_reg;
    logic [7:0]        s1_prefix_reg;

    logic              s1_ready;
    logic              s2_ready;
    logic              in_xfer;
    logic              sense_upd;
    logic              cmd_upd;
    logic              s1_load;

    logic signed [MV_W:0] diff2;
    logic signed [MV_W:0] diff3;
    logic [MV_W-1:0]   cell1_next;
    logic [MV_W-1:0]   cell2_next;
    logic [MV_W-1:0]   cell3_next;
    logic [MV_W-1:0]   pack_next;
    logic [MV_W-1:0]   span_full;
    logic [11:0]       span;
    logic [24:0]       pct_prod;
    logic [PCT_W-1:0]  pct_next;
    logic [7:0]        prefix_next;

    logic              is_cap;
    logic [PROD_W-1:0] value;

    sbwr_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = !s1_ready;
    assign in_xfer   = in_valid && !in_stall;
    assign sense_upd = in_xfer && (mode == MODE_SENSE);
    assign cmd_upd   = in_xfer && (mode == MODE_CMD);
    assign s1_load   = in_xfer && (mode == MODE_READ) && is_word_cmd(cmd_reg);

    // sensor update
    assign diff2 = $signed({1'b0, tap2_mv}) - $signed({1'b0, tap1_mv});
    assign diff3 = $signed({1'b0, pack_mv}) - $signed({1'b0, tap2_mv});

    assign cell1_next = (tap1_mv < CELL_FLOOR) ? CELL_FLOOR : tap1_mv;
    assign cell2_next = (diff2 < $signed({1'b0, CELL_FLOOR})) ? CELL_FLOOR
                                                               : diff2[MV_W-1:0];
    assign cell3_next = (diff3 < $signed({1'b0, CELL_FLOOR})) ? CELL_FLOOR
                                                               : diff3[MV_W-1:0];
    assign pack_next  = (pack_mv < PACK_FLOOR) ? PACK_FLOOR : pack_mv;

    assign span_full = pack_next - PACK_EMPTY;
    assign span      = (pack_next < PACK_EMPTY) ? 12'd0 :
                       (pack_next > PACK_FULL)  ? 12'(PACK_FULL - PACK_EMPTY) :
                                                  span_full[11:0];
    assign pct_prod  = 25'(span) * 25'(PCT_MUL);
    assign pct_next  = pct_prod[PCT_SHIFT+PCT_W-1:PCT_SHIFT];

    // crc over address, command and read address
    assign prefix_next = CRC_TABLE[CRC_TABLE[CRC_TABLE[ADDR_WRITE] ^ command_byte]
                                   ^ ADDR_READ];

    // word select
    always_comb
    begin
        is_cap = 1'b0;
        value  = '0;
        unique case (cmd_reg)
            CMD_TEMP:       value = PROD_W'(cfg.temperature_value);
            CMD_VOLTAGE:    value = PROD_W'(pack_reg);
            CMD_CURRENT:    value = PROD_W'(draw_reg);
            CMD_REL_CHARGE: value = PROD_W'(pct_reg);
            CMD_REM_CAP:
            begin
                is_cap = 1'b1;
                value  = PROD_W'(cfg.design_capacity) * PROD_W'(pct_reg);
            end
            CMD_FULL_CAP:   value = PROD_W'(cfg.full_capacity);
            CMD_CYCLES:     value = PROD_W'(cfg.cycle_total);
            CMD_CELL_ONE:   value = PROD_W'(cell1_reg);
            CMD_CELL_TWO:   value = PROD_W'(cell2_reg);
            CMD_CELL_THREE: value = PROD_W'(cell3_reg);
            default:        value = '0;
        endcase
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s2_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            cmd_reg      <= '0;
            prefix_reg   <= PREFIX_RST;
            cell1_reg    <= '0;
            cell2_reg    <= '0;
            cell3_reg    <= '0;
            pack_reg     <= '0;
            draw_reg     <= '0;
            pct_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (cmd_upd)
            begin
                cmd_reg    <= command_byte;
                prefix_reg <= prefix_next;
            end
            if (sense_upd)
            begin
                cell1_reg <= cell1_next;
                cell2_reg <= cell2_next;
                cell3_reg <= cell3_next;
                pack_reg  <= pack_next;
                draw_reg  <= current_ma;
                pct_reg   <= pct_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_is_cap_reg <= is_cap;
            s1_value_reg  <= value;
            s1_prefix_reg <= prefix_reg;
        end
    end

    sbwr_reply u_reply
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_valid   (s1_valid_reg),
        .s1_ready   (s2_ready),
        .s1_is_cap  (s1_is_cap_reg),
        .s1_value   (s1_value_reg),
        .s1_prefix  (s1_prefix_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .reply_byte (reply_byte),
        .last_byte  (last_byte)
    );

endmodule

// ===== sv/sbwr_regs.sv =====
// ----------------------------------------------------------------------------
// sbwr_regs
// apb register file holding the capacity, cycle count and temperature words
// ----------------------------------------------------------------------------
module sbwr_regs
    import sbwr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_index;
    logic       wr_en;

    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                REG_DESIGN_CAP: cfg_next.design_capacity   = pwdata[WORD_W-1:0];
                REG_FULL_CAP:   cfg_next.full_capacity     = pwdata[WORD_W-1:0];
                REG_CYCLES:     cfg_next.cycle_total       = pwdata[WORD_W-1:0];
                REG_TEMP:       cfg_next.temperature_value = pwdata[WORD_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_DESIGN_CAP: prdata = {16'd0, cfg_reg.design_capacity};
            REG_FULL_CAP:   prdata = {16'd0, cfg_reg.full_capacity};
            REG_CYCLES:     prdata = {16'd0, cfg_reg.cycle_total};
            REG_TEMP:       prdata = {16'd0, cfg_reg.temperature_value};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.design_capacity   <= DESIGN_CAP_RST;
            cfg_reg.full_capacity     <= FULL_CAP_RST;
            cfg_reg.cycle_total       <= CYCLES_RST;
            cfg_reg.temperature_value <= TEMP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/sbwr_reply.sv =====
// ----------------------------------------------------------------------------
// sbwr_reply
// word reply stage: finishes the remaining capacity division, computes the
// pec and sends low byte, high byte and pec as three output transfers
// ----------------------------------------------------------------------------
module sbwr_reply
    import sbwr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s1_valid,
    output logic              s1_ready,
    input  logic              s1_is_cap,
    input  logic [PROD_W-1:0] s1_value,
    input  logic [7:0]        s1_prefix,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        reply_byte,
    output logic              last_byte
);

    logic              s2_valid_reg;
    logic              s2_valid_next;
    logic [WORD_W-1:0] s2_word_reg;
    logic [7:0]        s2_prefix_reg;
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    logic [7:0]        byte0_reg;
    logic [7:0]        byte1_reg;
    logic [7:0]        byte2_reg;

    logic [46:0]       cap_prod;
    logic [WORD_W-1:0] word;
    logic              buf_free;
    logic              s2_ready;
    logic              load;
    logic              xfer;
    logic [7:0]        crc_lo;
    logic [7:0]        crc_hi;

    assign cap_prod = 47'(s1_value) * 47'(CAP_MUL);
    assign word     = s1_is_cap ? cap_prod[CAP_SHIFT+WORD_W-1:CAP_SHIFT]
                                : s1_value[WORD_W-1:0];

    assign out_valid  = (cnt_reg != 2'd0);
    assign reply_byte = byte0_reg;
    assign last_byte  = (cnt_reg == 2'd1);
    assign xfer       = out_valid && !out_stall;

    assign buf_free = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && !out_stall);
    assign load     = s2_valid_reg && buf_free;
    assign s2_ready = !s2_valid_reg || buf_free;
    assign s1_ready = s2_ready;

    assign crc_lo = CRC_TABLE[s2_prefix_reg ^ s2_word_reg[7:0]];
    assign crc_hi = CRC_TABLE[crc_lo ^ s2_word_reg[15:8]];

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (s1_valid && s2_ready)
        begin
            s2_valid_next = 1'b1;
        end
        else if (load)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load)
        begin
            cnt_next = 2'd3;
        end
        else if (xfer)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            cnt_reg      <= 2'd0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid && s2_ready)
        begin
            s2_word_reg   <= word;
            s2_prefix_reg <= s1_prefix;
        end
        if (load)
        begin
            byte0_reg <= s2_word_reg[7:0];
            byte1_reg <= s2_word_reg[15:8];
            byte2_reg <= crc_hi;
        end
        else if (xfer)
        begin
            byte0_reg <= byte1_reg;
            byte1_reg <= byte2_reg;
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// testbench for smart_battery_word_responder_core. a directed pass covers the
// sensor floors, a negative tap difference, every word command, unknown
// commands and the unused mode. random traffic follows under several register
// settings and idle/stall mixes. an in-bench model of the responder predicts
// each reply byte and its last flag, and every output transfer is checked
// against the oldest prediction
// ----------------------------------------------------------------------------
module tb_top
    import sbwr_pkg::*;
();

    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          MAX_GAP       = 24;
    localparam logic [1:0]  MODE_UNUSED   = 2'd3;
    localparam logic [7:0]  CMD_UNKNOWN_LO = 8'h00;
    localparam logic [7:0]  CMD_UNKNOWN_HI = 8'hFF;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0] pwdata       = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic [1:0]        mode         = MODE_SENSE;
    logic [7:0]        command_byte = '0;
    logic [MV_W-1:0]   tap1_mv      = '0;
    logic [MV_W-1:0]   tap2_mv      = '0;
    logic [MV_W-1:0]   pack_mv      = '0;
    logic [WORD_W-1:0] current_ma   = '0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic [7:0]        reply_byte;
    logic              last_byte;

    int          idle_pct  = 0;
    int          stall_pct = 0;
    int unsigned cycles    = 0;

    always #5 clk = ~clk;

    smart_battery_word_responder_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .command_byte (command_byte),
        .tap1_mv      (tap1_mv),
        .tap2_mv      (tap2_mv),
        .pack_mv      (pack_mv),
        .current_ma   (current_ma),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .reply_byte   (reply_byte),
        .last_byte    (last_byte)
    );

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } reply_t;

    class battery_reply_model;
        cfg_t              regs;
        logic [7:0]        command;
        logic [MV_W-1:0]   cell_one;
        logic [MV_W-1:0]   cell_two;
        logic [MV_W-1:0]   cell_three;
        logic [MV_W-1:0]   pack_level;
        logic [WORD_W-1:0] draw;
        logic [PCT_W-1:0]  charge;
        reply_t            expected_bytes[$];
        int                errors;

        function new();
            regs.design_capacity   = DESIGN_CAP_RST;
            regs.full_capacity     = FULL_CAP_RST;
            regs.cycle_total       = CYCLES_RST;
            regs.temperature_value = TEMP_RST;
            command    = '0;
            cell_one   = '0;
            cell_two   = '0;
            cell_three = '0;
            pack_level = '0;
            draw       = '0;
            charge     = '0;
            errors     = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [WORD_W-1:0] value);
            case (idx)
                REG_DESIGN_CAP: regs.design_capacity   = value;
                REG_FULL_CAP:   regs.full_capacity     = value;
                REG_CYCLES:     regs.cycle_total       = value;
                default:        regs.temperature_value = value;
            endcase
        endfunction

        function logic [WORD_W-1:0] reg_value(logic [1:0] idx);
            case (idx)
                REG_DESIGN_CAP: return regs.design_capacity;
                REG_FULL_CAP:   return regs.full_capacity;
                REG_CYCLES:     return regs.cycle_total;
                default:        return regs.temperature_value;
            endcase
        endfunction

        function logic [7:0] crc_byte(logic [7:0] crc, logic [7:0] b);
            logic [7:0] c;
            c = crc ^ b;
            for (int k = 0; k < 8; k++)
            begin
                c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
            end
            return c;
        endfunction

        function int at_least(int v, int lo);
            return (v < lo) ? lo : v;
        endfunction

        function void absorb_item(logic [1:0] m, logic [7:0] cmd,
                                  logic [MV_W-1:0] t1, logic [MV_W-1:0] t2,
                                  logic [MV_W-1:0] pk, logic [WORD_W-1:0] cur);
            int                clamped;
            logic [WORD_W-1:0] word;
            logic [7:0]        crc;
            logic              known;
            reply_t            r;
            case (m)
                MODE_SENSE:
                begin
                    cell_one   = MV_W'(at_least(int'(t1), int'(CELL_FLOOR)));
                    cell_two   = MV_W'(at_least(int'(t2) - int'(t1), int'(CELL_FLOOR)));
                    cell_three = MV_W'(at_least(int'(pk) - int'(t2), int'(CELL_FLOOR)));
                    pack_level = MV_W'(at_least(int'(pk), int'(PACK_FLOOR)));
                    clamped    = int'(pack_level);
                    if (clamped < int'(PACK_EMPTY))
                        clamped = int'(PACK_EMPTY);
                    if (clamped > int'(PACK_FULL))
                        clamped = int'(PACK_FULL);
                    charge = PCT_W'((clamped - int'(PACK_EMPTY)) / 36);
                    draw   = cur;
                end
                MODE_CMD:
                    command = cmd;
                MODE_READ:
                begin
                    known = 1'b1;
                    word  = '0;
                    case (command)
                        CMD_TEMP:       word = regs.temperature_value;
                        CMD_VOLTAGE:    word = WORD_W'(pack_level);
                        CMD_CURRENT:    word = draw;
                        CMD_REL_CHARGE: word = WORD_W'(charge);
                        CMD_REM_CAP:
                            word = WORD_W'((int'(regs.design_capacity) * int'(charge)) / 100);
                        CMD_FULL_CAP:   word = regs.full_capacity;
                        CMD_CYCLES:     word = regs.cycle_total;
                        CMD_CELL_ONE:   word = WORD_W'(cell_one);
                        CMD_CELL_TWO:   word = WORD_W'(cell_two);
                        CMD_CELL_THREE: word = WORD_W'(cell_three);
                        default:        known = 1'b0;
                    endcase
                    if (known)
                    begin
                        crc = crc_byte(8'h00, ADDR_WRITE);
                        crc = crc_byte(crc, command);
                        crc = crc_byte(crc, ADDR_READ);
                        crc = crc_byte(crc, word[7:0]);
                        crc = crc_byte(crc, word[15:8]);
                        r.data = word[7:0];
                        r.last = 1'b0;
                        expected_bytes.push_back(r);
                        r.data = word[15:8];
                        expected_bytes.push_back(r);
                        r.data = crc;
                        r.last = 1'b1;
                        expected_bytes.push_back(r);
                    end
                end
                default:
                    ;
            endcase
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_byte(logic [7:0] value, logic last);
            reply_t want;
            if (expected_bytes.size() == 0)
            begin
                report($sformatf("reply byte %02h (last %b) with nothing pending", value, last));
                return;
            end
            want = expected_bytes.pop_front();
            if (value !== want.data)
                report($sformatf("reply byte %02h, predicted %02h", value, want.data));
            if (last !== want.last)
                report($sformatf("last flag %b, predicted %b", last, want.last));
        endtask

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    battery_reply_model replies;

    // output side: check each transfer, then pick the next stall
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            replies.check_byte(reply_byte, last_byte);
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [7:0] word_cmd_at(int i);
        case (i)
            0:       return CMD_TEMP;
            1:       return CMD_VOLTAGE;
            2:       return CMD_CURRENT;
            3:       return CMD_REL_CHARGE;
            4:       return CMD_REM_CAP;
            5:       return CMD_FULL_CAP;
            6:       return CMD_CYCLES;
            7:       return CMD_CELL_ONE;
            8:       return CMD_CELL_TWO;
            default: return CMD_CELL_THREE;
        endcase
    endfunction

    task send_item(logic [1:0] m, logic [7:0] cmd, logic [MV_W-1:0] t1,
                   logic [MV_W-1:0] t2, logic [MV_W-1:0] pk, logic [WORD_W-1:0] cur);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= m;
        command_byte <= cmd;
        tap1_mv      <= t1;
        tap2_mv      <= t2;
        pack_mv      <= pk;
        current_ma   <= cur;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        replies.absorb_item(m, cmd, t1, t2, pk, cur);
    endtask

    task send_op(logic [1:0] m, logic [7:0] cmd);
        send_item(m, cmd, MV_W'($urandom), MV_W'($urandom), MV_W'($urandom),
                  WORD_W'($urandom));
    endtask

    task send_sensor(logic [MV_W-1:0] t1, logic [MV_W-1:0] t2, logic [MV_W-1:0] pk,
                     logic [WORD_W-1:0] cur);
        send_item(MODE_SENSE, 8'($urandom), t1, t2, pk, cur);
    endtask

    task drain_replies(int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (replies.pending() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task write_reg(logic [1:0] idx, logic [WORD_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        replies.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task read_reg(logic [1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== DATA_W'(replies.reg_value(idx)))
            replies.report($sformatf("register %0d reads %08h, predicted %08h",
                                     idx, prdata, replies.reg_value(idx)));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task apply_setting(logic [WORD_W-1:0] design_cap, logic [WORD_W-1:0] full,
                       logic [WORD_W-1:0] cyc, logic [WORD_W-1:0] temp);
        write_reg(REG_DESIGN_CAP, design_cap);
        write_reg(REG_FULL_CAP, full);
        write_reg(REG_CYCLES, cyc);
        write_reg(REG_TEMP, temp);
        read_reg(REG_DESIGN_CAP);
        read_reg(REG_FULL_CAP);
        read_reg(REG_CYCLES);
        read_reg(REG_TEMP);
    endtask

    task directed_items();
        // negative tap difference on cell two
        send_sensor(14'd5000, 14'd3000, 14'd12000, 16'h8001);
        for (int i = 0; i < 10; i++)
        begin
            send_op(MODE_CMD, word_cmd_at(i));
            send_op(MODE_READ, 8'($urandom));
        end
        // all fields at full scale
        send_sensor('1, '1, '1, '1);
        send_op(MODE_CMD, CMD_REM_CAP);
        send_op(MODE_READ, 8'($urandom));
        // all zero, floors everywhere
        send_sensor('0, '0, '0, '0);
        send_op(MODE_READ, 8'($urandom));
        send_op(MODE_CMD, CMD_UNKNOWN_HI);
        send_op(MODE_READ, 8'($urandom));
        send_op(MODE_CMD, CMD_UNKNOWN_LO);
        send_op(MODE_UNUSED, 8'($urandom));
        send_op(MODE_READ, 8'($urandom));
    endtask

    task random_traffic(int n);
        int sent;
        int pick;
        int reads;
        int t1;
        int t2;
        int pk;
        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(99);
            if (pick < 25)
            begin
                if ($urandom_range(1) == 1)
                begin
                    t1 = $urandom_range(4400, 2500);
                    t2 = t1 + $urandom_range(4400, 2500);
                    pk = t2 + $urandom_range(4400, 2500);
                end
                else
                begin
                    t1 = $urandom_range(16383);
                    t2 = $urandom_range(16383);
                    pk = $urandom_range(16383);
                end
                send_sensor(MV_W'(t1), MV_W'(t2), MV_W'(pk), WORD_W'($urandom));
                sent++;
            end
            else if (pick < 80)
            begin
                send_op(MODE_CMD, word_cmd_at($urandom_range(9)));
                reads = $urandom_range(3, 1);
                repeat (reads) send_op(MODE_READ, 8'($urandom));
                sent += 1 + reads;
            end
            else if (pick < 90)
            begin
                send_op(MODE_CMD, 8'($urandom));
                send_op(MODE_READ, 8'($urandom));
                sent += 2;
            end
            else if (pick < 95)
            begin
                send_op(MODE_READ, 8'($urandom));
                sent++;
            end
            else
                send_op(MODE_UNUSED, 8'($urandom));
        end
    endtask

    initial
    begin
        replies = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        read_reg(REG_DESIGN_CAP);
        read_reg(REG_FULL_CAP);
        read_reg(REG_CYCLES);
        read_reg(REG_TEMP);
        directed_items();
        drain_replies(SETTLE_CYCLES);

        apply_setting('1, '1, '1, '1);
        random_traffic(70);
        drain_replies(SETTLE_CYCLES);

        idle_pct = 56;
        apply_setting('0, '0, '0, '0);
        random_traffic(35);
        // hold off until every reply byte is out
        drain_replies(0);
        random_traffic(35);
        drain_replies(SETTLE_CYCLES);

        idle_pct  = 0;
        stall_pct = 56;
        apply_setting(WORD_W'($urandom), WORD_W'($urandom), WORD_W'($urandom),
                      WORD_W'($urandom));
        random_traffic(70);
        drain_replies(SETTLE_CYCLES);

        idle_pct  = 29;
        stall_pct = 29;
        apply_setting('1, WORD_W'($urandom), WORD_W'($urandom), '0);
        random_traffic(70);
        drain_replies(SETTLE_CYCLES);

        if (replies.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/sbwr_pkg.sv
sv/sbwr_regs.sv
sv/sbwr_reply.sv
sv/smart_battery_word_responder_core.sv
tb/sv/tb_top.sv
